// ----- src/point_charge_field_magnitude_defines.svh -----
// ----------------------------------------------------------------------------
// point charge field magnitude: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_CHARGE_FIELD_MAGNITUDE_DEFINES_SVH
`define POINT_CHARGE_FIELD_MAGNITUDE_DEFINES_SVH

// same-cycle implication
`define PCFM_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcfm assertion failed");

// next-cycle implication
`define PCFM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcfm assertion failed");

`endif

// ----- src/pcfm_pkg.sv -----
// ----------------------------------------------------------------------------
// pcfm_pkg
// Types, widths and constants of the point charge field magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcfm_pkg;

	localparam int MAX_CHARGES = 16;
	localparam int SLOT_W      = $clog2(MAX_CHARGES);
	localparam int CNT_W       = 5;
	localparam int INDEX_BITS  = 12;
	localparam int COORD_W     = 24;
	localparam int CFG_W       = 24;
	localparam int SPACING_W   = 23;
	localparam int PROD_W      = INDEX_BITS + SPACING_W;
	localparam int PX_W        = PROD_W + 2;
	localparam int DX_W        = PX_W + 1;
	localparam int R2_W        = 2 * DX_W + 1;
	localparam int S_W         = 55;
	localparam int F_W         = 44;
	localparam int FQ_W        = F_W + COORD_W;
	localparam int WIDE_W      = 128;
	localparam int TERM_W      = 54;
	localparam int FIELD_W     = 60;
	localparam int MAG_W       = 48;
	localparam int ITER_W      = 7;

	// coulomb scale: round(k * 1e-9 * 2^40) for q in nC and Q12.12 distances
	localparam logic [WIDE_W-1:0] F_NUM =
		(128'd89875517879979 << 40) + 128'd5000000000000;
	localparam logic [WIDE_W-1:0] F_WIDE  = F_NUM / 128'd10000000000000;
	localparam logic [F_W-1:0]    F_SCALE = F_WIDE[F_W-1:0];

	localparam logic [TERM_W-1:0] TERM_CAP = '1;
	localparam logic [MAG_W-1:0]  MAG_CAP  = '1;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_EVAL  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_SPACING  = 2'd2,
		REG_COUNT    = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ARITH_MUL,
		ARITH_DIV,
		ARITH_SQRT
	} arith_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_POS,
		ST_CHECK,
		ST_FETCH,
		ST_DIFF,
		ST_TEST,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_FQ,
		ST_NUMX,
		ST_DIVAX,
		ST_DIVBX,
		ST_NUMY,
		ST_DIVAY,
		ST_DIVBY,
		ST_NEXT,
		ST_MAGX,
		ST_MAGY,
		ST_MAGR,
		ST_DONE
	} step_t;

	typedef struct packed {
		step_t step;
		logic  ready;
		logic  load;
		logic  clear;
		logic  start;
		logic  launch;
		logic  capture;
		logic  emit;
	} dp_cmd_t;

	typedef struct packed {
		logic  in_valid;
		kind_t in_kind;
		logic  arith_done;
		logic  hit;
		logic  last;
		logic  out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- src/pcfm_ifs.sv -----
// ----------------------------------------------------------------------------
// pcfm channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcfm_in_if;
	logic                               valid;
	logic                               ready;
	pcfm_pkg::kind_t                    kind;
	logic [pcfm_pkg::SLOT_W-1:0]        slot;
	logic signed [pcfm_pkg::COORD_W-1:0] charge_x;
	logic signed [pcfm_pkg::COORD_W-1:0] charge_y;
	logic signed [pcfm_pkg::COORD_W-1:0] charge_value;
	logic [pcfm_pkg::INDEX_BITS-1:0]    col;
	logic [pcfm_pkg::INDEX_BITS-1:0]    row;

	modport source (output valid, kind, slot, charge_x, charge_y, charge_value, col, row,
		input ready);
	modport sink (input valid, kind, slot, charge_x, charge_y, charge_value, col, row,
		output ready);
endinterface

interface pcfm_out_if;
	logic                            valid;
	logic                            ready;
	logic [pcfm_pkg::INDEX_BITS-1:0] out_col;
	logic [pcfm_pkg::INDEX_BITS-1:0] out_row;
	logic [pcfm_pkg::MAG_W-1:0]      magnitude;
	logic [pcfm_pkg::MAG_W-1:0]      running_max;
	logic                            coincident;

	modport source (output valid, out_col, out_row, magnitude, running_max, coincident,
		input ready);
	modport sink (input valid, out_col, out_row, magnitude, running_max, coincident,
		output ready);
endinterface

`default_nettype wire

// ----- src/point_charge_field_magnitude.sv -----
// ----------------------------------------------------------------------------
// point_charge_field_magnitude
// Coulomb field magnitude at grid points over a table of point charges.
// ----------------------------------------------------------------------------
// channel   dir  handshake     beat
// in_ch     in   valid/ready   load charge, evaluate point or clear maximum
// out_ch    out  valid/ready   magnitude, running maximum, coincidence, indices
// cfg       in   cfg_we only   origin_x, origin_y, spacing, charge_count
//
// load and clear beats are taken while idle; an evaluation runs on the shared
// bit-serial unit for each active charge and for the final magnitude: multiplies
// run one bit of the second operand per cycle, divides and roots produce one
// quotient or root bit at a time.
// a finished result waits in the output register while the next beat is taken.
// asynchronous active-low reset; the charge table holds no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module point_charge_field_magnitude (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [1:0]                  cfg_index,
	input  wire [pcfm_pkg::CFG_W-1:0]  cfg_data,
	pcfm_in_if.sink                    in_ch,
	pcfm_out_if.source                 out_ch
);
	import pcfm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pcfm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	pcfm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

// ----- src/pcfm_arith.sv -----
// ----------------------------------------------------------------------------
// pcfm_arith
// Shared bit-serial unit: shift-add multiply, restoring divide, integer root.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_charge_field_magnitude_defines.svh"

module pcfm_arith (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  pcfm_pkg::arith_op_t          op,
	input  wire [pcfm_pkg::WIDE_W-1:0]   a,
	input  wire [pcfm_pkg::WIDE_W-1:0]   b,
	output logic                         busy,
	output logic                         done,
	output logic [pcfm_pkg::WIDE_W-1:0]  result
);
	import pcfm_pkg::*;

	localparam logic [ITER_W-1:0] DIV_ITERS  = ITER_W'(WIDE_W - 1);
	localparam logic [ITER_W-1:0] ROOT_ITERS = ITER_W'(WIDE_W / 2 - 1);

	arith_op_t          op_q;
	logic [WIDE_W-1:0]  acc_q, opa_q, opb_q;
	logic [WIDE_W:0]    rem_q;
	logic [ITER_W-1:0]  cnt_q;
	logic               busy_q, done_q;

	logic [WIDE_W-1:0]  mul_sum;
	logic [WIDE_W:0]    rem_div, rem_sq, trial;
	logic               div_ge, sq_ge, last_step;

	// one step of each operation
	always_comb begin
		mul_sum = acc_q + (opb_q[0] ? opa_q : '0);
		rem_div = {rem_q[WIDE_W-1:0], opa_q[WIDE_W-1]};
		div_ge  = rem_div >= {1'b0, opb_q};
		rem_sq  = {rem_q[WIDE_W-2:0], opa_q[WIDE_W-1:WIDE_W-2]};
		trial   = {acc_q[WIDE_W-2:0], 2'b01};
		sq_ge   = rem_sq >= trial;
		if (op_q == ARITH_MUL) begin
			last_step = opb_q[WIDE_W-1:1] == '0;
		end else begin
			last_step = cnt_q == '0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			done_q <= last_step;
		end else begin
			done_q <= 1'b0;
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			opa_q <= a;
			opb_q <= (op == ARITH_MUL) ? {{(WIDE_W/2){1'b0}}, b[WIDE_W/2-1:0]} : b;
			acc_q <= '0;
			rem_q <= '0;
			cnt_q <= (op == ARITH_DIV) ? DIV_ITERS : ROOT_ITERS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			unique case (op_q)
				ARITH_MUL: begin
					acc_q <= mul_sum;
					opa_q <= opa_q << 1;
					opb_q <= opb_q >> 1;
				end
				ARITH_DIV: begin
					rem_q <= div_ge ? rem_div - {1'b0, opb_q} : rem_div;
					acc_q <= {acc_q[WIDE_W-2:0], div_ge};
					opa_q <= opa_q << 1;
				end
				ARITH_SQRT: begin
					rem_q <= sq_ge ? rem_sq - trial : rem_sq;
					acc_q <= {acc_q[WIDE_W-2:0], sq_ge};
					opa_q <= opa_q << 2;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = acc_q;

	`PCFM_ASSERT_NEXT(a_done_single, done_q, !done_q)
	`PCFM_ASSERT_IMPL(a_start_when_free, start, !busy_q)
	`PCFM_ASSERT_NEXT(a_done_ends_busy, done_q, !busy_q || start)

endmodule

`default_nettype wire

// ----- src/pcfm_dp.sv -----
// ----------------------------------------------------------------------------
// pcfm_dp
// Datapath: configuration, charge table, field accumulators, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_charge_field_magnitude_defines.svh"

module pcfm_dp (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [1:0]                   cfg_index,
	input  wire [pcfm_pkg::CFG_W-1:0]   cfg_data,
	input  pcfm_pkg::dp_cmd_t           cmd,
	output pcfm_pkg::dp_stat_t          stat,
	pcfm_in_if.sink                     in_ch,
	pcfm_out_if.source                  out_ch
);
	import pcfm_pkg::*;

	// configuration
	logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [SPACING_W-1:0]      spacing_q;
	logic [CNT_W-1:0]          count_q;

	// charge table
	logic signed [COORD_W-1:0] tab_x [MAX_CHARGES];
	logic signed [COORD_W-1:0] tab_y [MAX_CHARGES];
	logic signed [COORD_W-1:0] tab_q [MAX_CHARGES];

	// working registers
	logic [INDEX_BITS-1:0]     col_q, row_q;
	logic signed [PX_W-1:0]    px_q, py_q;
	logic signed [COORD_W-1:0] ent_x_q, ent_y_q, ent_q_q;
	logic [DX_W-1:0]           ax_q, ay_q;
	logic                      sx_q, sy_q;
	logic [COORD_W-1:0]        qa_q;
	logic [R2_W-1:0]           r2_q;
	logic [S_W-1:0]            s_q;
	logic [FQ_W-1:0]           fq_q;
	logic [WIDE_W-1:0]         t_q;
	logic signed [FIELD_W-1:0] ex_q, ey_q;
	logic [CNT_W-1:0]          idx_q;
	logic                      coinc_q;
	logic [MAG_W-1:0]          mag_q, peak_q;

	// result register
	logic                      out_valid_q;
	logic [INDEX_BITS-1:0]     out_col_q, out_row_q;
	logic [MAG_W-1:0]          out_mag_q, out_max_q;
	logic                      out_coinc_q;

	// combinational terms
	logic [PROD_W-1:0]         prod_x, prod_y;
	logic signed [DX_W-1:0]    dx, dy;
	logic [CNT_W-1:0]          count_eff;
	logic                      hit;
	logic [FIELD_W-1:0]        abs_ex, abs_ey;
	logic [TERM_W-1:0]         term;
	logic signed [FIELD_W-1:0] term_s;
	logic [MAG_W-1:0]          mag_sat, peak_next;

	arith_op_t                 a_op;
	logic [WIDE_W-1:0]         a_opa, a_opb, a_res;
	logic                      a_busy, a_done;

	// grid position, offsets and coincidence test
	always_comb begin
		prod_x    = PROD_W'(col_q) * PROD_W'(spacing_q);
		prod_y    = PROD_W'(row_q) * PROD_W'(spacing_q);
		dx        = DX_W'(px_q) - DX_W'(ent_x_q);
		dy        = DX_W'(py_q) - DX_W'(ent_y_q);
		count_eff = (count_q > CNT_W'(MAX_CHARGES)) ? CNT_W'(MAX_CHARGES) : count_q;
		hit       = ((ax_q < DX_W'(spacing_q)) && (ay_q < DX_W'(spacing_q)))
			|| ((ax_q == '0) && (ay_q == '0));
		abs_ex    = ex_q[FIELD_W-1] ? FIELD_W'(-ex_q) : FIELD_W'(ex_q);
		abs_ey    = ey_q[FIELD_W-1] ? FIELD_W'(-ey_q) : FIELD_W'(ey_q);
		term      = (a_res[WIDE_W-1:TERM_W] != '0) ? TERM_CAP : a_res[TERM_W-1:0];
		term_s    = signed'({{(FIELD_W-TERM_W){1'b0}}, term});
		mag_sat   = (a_res[WIDE_W-1:MAG_W] != '0) ? MAG_CAP : a_res[MAG_W-1:0];
		peak_next = (mag_q > peak_q) ? mag_q : peak_q;
	end

	// operand selection for the shared unit
	always_comb begin
		a_op  = ARITH_MUL;
		a_opa = '0;
		a_opb = '0;
		unique case (cmd.step)
			ST_SQX: begin
				a_opa = WIDE_W'(ax_q);
				a_opb = WIDE_W'(ax_q);
			end
			ST_SQY: begin
				a_opa = WIDE_W'(ay_q);
				a_opb = WIDE_W'(ay_q);
			end
			ST_ROOT: begin
				a_op  = ARITH_SQRT;
				a_opa = WIDE_W'(r2_q) << 32;
			end
			ST_FQ: begin
				a_opa = WIDE_W'(F_SCALE);
				a_opb = WIDE_W'(qa_q);
			end
			ST_NUMX: begin
				a_opa = WIDE_W'(fq_q);
				a_opb = WIDE_W'(ax_q);
			end
			ST_NUMY: begin
				a_opa = WIDE_W'(fq_q);
				a_opb = WIDE_W'(ay_q);
			end
			ST_DIVAX, ST_DIVAY: begin
				a_op  = ARITH_DIV;
				a_opa = t_q << 16;
				a_opb = WIDE_W'(r2_q);
			end
			ST_DIVBX, ST_DIVBY: begin
				a_op  = ARITH_DIV;
				a_opa = t_q;
				a_opb = WIDE_W'(s_q);
			end
			ST_MAGX: begin
				a_opa = WIDE_W'(abs_ex);
				a_opb = WIDE_W'(abs_ex);
			end
			ST_MAGY: begin
				a_opa = WIDE_W'(abs_ey);
				a_opb = WIDE_W'(abs_ey);
			end
			ST_MAGR: begin
				a_op  = ARITH_SQRT;
				a_opa = t_q;
			end
			default: begin
				a_op = ARITH_MUL;
			end
		endcase
	end

	pcfm_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.launch),
		.op     (a_op),
		.a      (a_opa),
		.b      (a_opb),
		.busy   (a_busy),
		.done   (a_done),
		.result (a_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			spacing_q  <= SPACING_W'(256);
			count_q    <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X: origin_x_q <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y: origin_y_q <= cfg_data[COORD_W-1:0];
				REG_SPACING:  spacing_q  <= cfg_data[SPACING_W-1:0];
				REG_COUNT:    count_q    <= cfg_data[CNT_W-1:0];
				default:      count_q    <= count_q;
			endcase
		end
	end

	// charge table writes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tab_x[in_ch.slot] <= in_ch.charge_x;
			tab_y[in_ch.slot] <= in_ch.charge_y;
			tab_q[in_ch.slot] <= in_ch.charge_value;
		end
	end

	// per-point and per-charge working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			col_q <= in_ch.col;
			row_q <= in_ch.row;
		end
		if (cmd.step == ST_POS) begin
			px_q  <= PX_W'(origin_x_q) + signed'({2'b00, prod_x});
			py_q  <= PX_W'(origin_y_q) + signed'({2'b00, prod_y});
			ex_q  <= '0;
			ey_q  <= '0;
			idx_q <= '0;
		end
		if (cmd.step == ST_FETCH) begin
			ent_x_q <= tab_x[idx_q[SLOT_W-1:0]];
			ent_y_q <= tab_y[idx_q[SLOT_W-1:0]];
			ent_q_q <= tab_q[idx_q[SLOT_W-1:0]];
		end
		if (cmd.step == ST_DIFF) begin
			ax_q <= dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
			ay_q <= dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);
			sx_q <= dx[DX_W-1] ^ ent_q_q[COORD_W-1];
			sy_q <= dy[DX_W-1] ^ ent_q_q[COORD_W-1];
			qa_q <= ent_q_q[COORD_W-1] ? COORD_W'(-ent_q_q) : COORD_W'(ent_q_q);
		end
		if ((cmd.step == ST_TEST) && hit) begin
			mag_q <= '0;
		end
		if (cmd.step == ST_NEXT) begin
			idx_q <= idx_q + 1'b1;
		end
		// results of the shared unit
		if (cmd.capture) begin
			unique case (cmd.step)
				ST_SQX:             r2_q <= a_res[R2_W-1:0];
				ST_SQY:             r2_q <= r2_q + a_res[R2_W-1:0];
				ST_ROOT:            s_q  <= a_res[S_W-1:0];
				ST_FQ:              fq_q <= a_res[FQ_W-1:0];
				ST_NUMX, ST_NUMY,
				ST_DIVAX, ST_DIVAY,
				ST_MAGX:            t_q  <= a_res;
				ST_MAGY:            t_q  <= t_q + a_res;
				ST_DIVBX:           ex_q <= sx_q ? ex_q - term_s : ex_q + term_s;
				ST_DIVBY:           ey_q <= sy_q ? ey_q - term_s : ey_q + term_s;
				ST_MAGR:            mag_q <= mag_sat;
				default:            t_q  <= t_q;
			endcase
		end
	end

	// coincidence flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coinc_q <= 1'b0;
		end else if (cmd.step == ST_POS) begin
			coinc_q <= 1'b0;
		end else if (cmd.step == ST_TEST) begin
			coinc_q <= hit;
		end
	end

	// running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (cmd.clear) begin
			peak_q <= '0;
		end else if (cmd.emit) begin
			peak_q <= peak_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_col_q   <= col_q;
			out_row_q   <= row_q;
			out_mag_q   <= mag_q;
			out_max_q   <= peak_next;
			out_coinc_q <= coinc_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_col     = out_col_q;
	assign out_ch.out_row     = out_row_q;
	assign out_ch.magnitude   = out_mag_q;
	assign out_ch.running_max = out_max_q;
	assign out_ch.coincident  = out_coinc_q;
	assign in_ch.ready        = cmd.ready;

	assign stat.in_valid   = in_ch.valid;
	assign stat.in_kind    = in_ch.kind;
	assign stat.arith_done = a_done;
	assign stat.hit        = hit;
	assign stat.last       = idx_q >= count_eff;
	assign stat.out_free   = !out_valid_q || out_ch.ready;

	`PCFM_ASSERT_IMPL(a_coinc_zero, out_valid_q && out_coinc_q, out_mag_q == '0)
	`PCFM_ASSERT_IMPL(a_max_covers, out_valid_q, out_max_q >= out_mag_q)
	`PCFM_ASSERT_NEXT(a_peak_cleared, cmd.clear, peak_q == '0)
	`PCFM_ASSERT_IMPL(a_launch_free, cmd.launch, !a_busy)

endmodule

`default_nettype wire

// ----- src/pcfm_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcfm_ctrl
// Sequencer: walks the charge table and steps the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pcfm_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pcfm_pkg::dp_stat_t  stat,
	output pcfm_pkg::dp_cmd_t   cmd
);
	import pcfm_pkg::*;

	step_t state_q, state_d;
	logic  run_q;
	logic  is_arith, accept;

	always_comb begin
		unique case (state_q)
			ST_SQX, ST_SQY, ST_ROOT, ST_FQ, ST_NUMX, ST_DIVAX, ST_DIVBX,
			ST_NUMY, ST_DIVAY, ST_DIVBY, ST_MAGX, ST_MAGY, ST_MAGR: is_arith = 1'b1;
			default: is_arith = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.in_valid && (stat.in_kind == KIND_EVAL)) state_d = ST_POS;
			end
			ST_POS:   state_d = ST_CHECK;
			ST_CHECK: state_d = stat.last ? ST_MAGX : ST_FETCH;
			ST_FETCH: state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_TEST;
			ST_TEST:  state_d = stat.hit ? ST_DONE : ST_SQX;
			ST_SQX:   if (stat.arith_done) state_d = ST_SQY;
			ST_SQY:   if (stat.arith_done) state_d = ST_ROOT;
			ST_ROOT:  if (stat.arith_done) state_d = ST_FQ;
			ST_FQ:    if (stat.arith_done) state_d = ST_NUMX;
			ST_NUMX:  if (stat.arith_done) state_d = ST_DIVAX;
			ST_DIVAX: if (stat.arith_done) state_d = ST_DIVBX;
			ST_DIVBX: if (stat.arith_done) state_d = ST_NUMY;
			ST_NUMY:  if (stat.arith_done) state_d = ST_DIVAY;
			ST_DIVAY: if (stat.arith_done) state_d = ST_DIVBY;
			ST_DIVBY: if (stat.arith_done) state_d = ST_NEXT;
			ST_NEXT:  state_d = ST_CHECK;
			ST_MAGX:  if (stat.arith_done) state_d = ST_MAGY;
			ST_MAGY:  if (stat.arith_done) state_d = ST_MAGR;
			ST_MAGR:  if (stat.arith_done) state_d = ST_DONE;
			ST_DONE:  if (stat.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		accept      = (state_q == ST_IDLE) && stat.in_valid;
		cmd.step    = state_q;
		cmd.ready   = state_q == ST_IDLE;
		cmd.load    = accept && (stat.in_kind == KIND_LOAD);
		cmd.clear   = accept && (stat.in_kind == KIND_CLEAR);
		cmd.start   = accept && (stat.in_kind == KIND_EVAL);
		cmd.launch  = is_arith && !run_q;
		cmd.capture = is_arith && stat.arith_done;
		cmd.emit    = (state_q == ST_DONE) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (is_arith && !run_q) begin
				run_q <= 1'b1;
			end else if (stat.arith_done) begin
				run_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- verif/point_charge_field_magnitude_test.sv -----
// ----------------------------------------------------------------------------
// point_charge_field_magnitude_test
// Self-checking bench for the point charge field magnitude block. Charge
// loads, point evaluations, maximum clears and ignored beats go in through
// the input channel. A predictor works out magnitude, running maximum and
// coincidence for each evaluation, and each result beat is checked against
// it. Phases change origin, spacing and charge count between idle periods,
// under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_charge_field_magnitude_test;
	import pcfm_pkg::*;

	localparam int WATCH_LIMIT = 100000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		kind_t       kind;
		logic [3:0]  slot;
		logic [23:0] cx;
		logic [23:0] cy;
		logic [23:0] cq;
		logic [11:0] col;
		logic [11:0] row;
	} beat_t;

	typedef struct {
		logic [11:0] col;
		logic [11:0] row;
		logic [47:0] mag;
		logic [47:0] peak;
		logic        coin;
	} field_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_ORIGIN_X;
	logic [23:0] cfg_data = '0;

	pcfm_in_if  in_ch();
	pcfm_out_if out_ch();

	point_charge_field_magnitude u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	// predictor state
	logic [23:0] org_x, org_y;
	logic [22:0] step_sp;
	logic [4:0]  active_cnt;
	longint      pos_x[16], pos_y[16], chg_q[16];
	logic [47:0] peak_mag;
	logic [127:0] coulomb_f;

	beat_t  pending[$];
	field_t field_expect[$];
	int     fail_count = 0;
	int     idle_pct = 0, stall_pct = 0;
	bit     hold_go = 0, hold_used = 0;
	int     hold_left = 0;
	int     watch = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic logic [63:0] isqrt128(logic [127:0] n);
		logic [127:0] res, bitv, t;
		res = 0;
		for (int i = 63; i >= 0; i--) begin
			bitv = 128'd1 << (2 * i);
			t = res + bitv;
			if (n >= t) begin
				n = n - t;
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
		end
		return res[63:0];
	endfunction

	function automatic logic [63:0] mag64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// coulomb sum over the active charges for one grid point
	function automatic field_t predict_field(beat_t b);
		field_t       r;
		longint       px, py, dx, dy, ex, ey, sv;
		logic [63:0]  ax, ay, qa, d, axs, ays, s;
		logic [127:0] r2, fq, t;
		int           cnt;
		bit           neg;
		ex = 0;
		ey = 0;
		r.coin = 0;
		px = longint'($signed(org_x)) + longint'(b.col) * longint'(step_sp);
		py = longint'($signed(org_y)) + longint'(b.row) * longint'(step_sp);
		cnt = active_cnt > 16 ? 16 : active_cnt;
		for (int i = 0; i < cnt; i++) begin
			dx = px - pos_x[i];
			dy = py - pos_y[i];
			ax = mag64(dx);
			ay = mag64(dy);
			qa = mag64(chg_q[i]);
			if ((ax < step_sp && ay < step_sp) || (ax == 0 && ay == 0)) begin
				r.coin = 1;
				break;
			end
			r2 = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
			s = isqrt128(r2 << 32);
			fq = coulomb_f * {64'd0, qa};
			for (int c = 0; c < 2; c++) begin
				d = c == 0 ? ax : ay;
				t = (((fq * {64'd0, d}) << 16) / r2) / {64'd0, s};
				if (t > TERM_CAP) t = TERM_CAP;
				neg = ((c == 0 ? dx : dy) < 0) != (chg_q[i] < 0);
				sv = neg ? -longint'(t[63:0]) : longint'(t[63:0]);
				if (c == 0) ex += sv;
				else ey += sv;
			end
		end
		if (r.coin) begin
			r.mag = 0;
		end else begin
			axs = mag64(ex);
			ays = mag64(ey);
			s = isqrt128({64'd0, axs} * {64'd0, axs} + {64'd0, ays} * {64'd0, ays});
			r.mag = s > MAG_CAP ? MAG_CAP : s[47:0];
		end
		if (r.mag > peak_mag) peak_mag = r.mag;
		r.peak = peak_mag;
		r.col = b.col;
		r.row = b.row;
		return r;
	endfunction

	// apply one accepted input beat to the predictor
	task automatic absorb_beat(beat_t b);
		case (b.kind)
			KIND_LOAD: begin
				pos_x[b.slot] = longint'($signed(b.cx));
				pos_y[b.slot] = longint'($signed(b.cy));
				chg_q[b.slot] = longint'($signed(b.cq));
			end
			KIND_CLEAR: peak_mag = 0;
			KIND_EVAL: field_expect.insert(field_expect.size(), predict_field(b));
			default: ;
		endcase
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		beat_t nb, cur;
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_ch.kind <= KIND_NOP;
			in_ch.slot <= '0;
			in_ch.charge_x <= '0;
			in_ch.charge_y <= '0;
			in_ch.charge_value <= '0;
			in_ch.col <= '0;
			in_ch.row <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) begin
				cur.kind = in_ch.kind;
				cur.slot = in_ch.slot;
				cur.cx = in_ch.charge_x;
				cur.cy = in_ch.charge_y;
				cur.cq = in_ch.charge_value;
				cur.col = in_ch.col;
				cur.row = in_ch.row;
				absorb_beat(cur);
			end
			if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nb = pending.pop_front();
				in_ch.valid <= 1;
				in_ch.kind <= nb.kind;
				in_ch.slot <= nb.slot;
				in_ch.charge_x <= nb.cx;
				in_ch.charge_y <= nb.cy;
				in_ch.charge_value <= nb.cq;
				in_ch.col <= nb.col;
				in_ch.row <= nb.row;
			end else begin
				in_ch.valid <= 0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and ready
	always @(posedge clk or negedge arst_n) begin
		field_t e;
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (field_expect.size() == 0) begin
					$error("unexpected result beat col %0d row %0d", out_ch.out_col,
						out_ch.out_row);
					fail_count++;
				end else begin
					e = field_expect.pop_front();
					if (out_ch.out_col !== e.col) begin
						$error("out_col exp %0d got %0d", e.col, out_ch.out_col);
						fail_count++;
					end
					if (out_ch.out_row !== e.row) begin
						$error("out_row exp %0d got %0d", e.row, out_ch.out_row);
						fail_count++;
					end
					if (out_ch.magnitude !== e.mag) begin
						$error("magnitude exp %0d got %0d", e.mag, out_ch.magnitude);
						fail_count++;
					end
					if (out_ch.running_max !== e.peak) begin
						$error("running_max exp %0d got %0d", e.peak, out_ch.running_max);
						fail_count++;
					end
					if (out_ch.coincident !== e.coin) begin
						$error("coincident exp %0d got %0d", e.coin, out_ch.coincident);
						fail_count++;
					end
				end
			end
			out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			watch <= 0;
		end else begin
			watch <= watch + 1;
			if (watch >= WATCH_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_ORIGIN_X: org_x = val;
			REG_ORIGIN_Y: org_y = val;
			REG_SPACING:  step_sp = val[22:0];
			default:      active_cnt = val[4:0];
		endcase
	endtask

	task automatic set_regs(logic [23:0] ox, logic [23:0] oy, logic [22:0] sp,
		logic [4:0] cnt);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_SPACING, {1'b0, sp});
		write_reg(REG_COUNT, {19'd0, cnt});
	endtask

	// wait until the block has drained, then let the last load settle
	task automatic drain();
		while (pending.size() != 0 || field_expect.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic beat_t make_beat(kind_t k, logic [3:0] sl, logic [23:0] x,
		logic [23:0] y, logic [23:0] q, logic [11:0] c, logic [11:0] r);
		beat_t b;
		b.kind = k;
		b.slot = sl;
		b.cx = x;
		b.cy = y;
		b.cq = q;
		b.col = c;
		b.row = r;
		return b;
	endfunction

	// append one beat to the driver queue
	task automatic queue_beat(beat_t b);
		pending.insert(pending.size(), b);
	endtask

	// random coordinate, half of them close to the grid
	function automatic logic [23:0] rand_coord(logic [23:0] org);
		if ($urandom_range(1))
			return 24'($urandom());
		return org + 24'($urandom_range(15)) * {1'b0, step_sp} + 24'($urandom_range(600))
			- 24'd300;
	endfunction

	function automatic logic [11:0] rand_index();
		return $urandom_range(1) ? 12'($urandom()) : 12'($urandom_range(15));
	endfunction

	task automatic random_beats(int n);
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			if (p < 50)
				queue_beat(make_beat(KIND_EVAL, 4'($urandom()), 24'($urandom()),
					24'($urandom()), 24'($urandom()), rand_index(), rand_index()));
			else if (p < 82)
				queue_beat(make_beat(KIND_LOAD, 4'($urandom()), rand_coord(org_x),
					rand_coord(org_y), 24'($urandom()), 12'($urandom()), 12'($urandom())));
			else if (p < 92)
				queue_beat(make_beat(KIND_CLEAR, 4'($urandom()), 24'($urandom()),
					24'($urandom()), 24'($urandom()), 12'($urandom()), 12'($urandom())));
			else
				queue_beat(make_beat(KIND_NOP, 4'($urandom()), 24'($urandom()),
					24'($urandom()), 24'($urandom()), 12'($urandom()), 12'($urandom())));
		end
	endtask

	task automatic run_phase(logic [23:0] ox, logic [23:0] oy, logic [22:0] sp,
		logic [4:0] cnt, int idle, int stall, int n);
		set_regs(ox, oy, sp, cnt);
		idle_pct = idle;
		stall_pct = stall;
		random_beats(n);
		drain();
	endtask

	initial begin
		org_x = 0;
		org_y = 0;
		step_sp = 256;
		active_cnt = 0;
		peak_mag = 0;
		coulomb_f = ((128'd89875517879979 << 40) + 128'd5000000000000) / 128'd10000000000000;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// directed: fill the table with extreme charges, no charges active
		queue_beat(make_beat(KIND_LOAD, 0, 0, 0, 24'd1000, 0, 0));
		queue_beat(make_beat(KIND_LOAD, 1, 24'h7fffff, 24'h800000, 24'h7fffff, 0, 0));
		queue_beat(make_beat(KIND_LOAD, 2, 24'h800000, 24'h7fffff, 24'h800000, 0, 0));
		for (int i = 3; i < 16; i++)
			queue_beat(make_beat(KIND_LOAD, 4'(i), 24'($urandom()), 24'($urandom()),
				24'($urandom()), 0, 0));
		queue_beat(make_beat(KIND_EVAL, 0, 0, 0, 0, 12'd4095, 12'd4095));
		queue_beat(make_beat(KIND_NOP, 4'hf, '1, '1, '1, '1, '1));
		queue_beat(make_beat(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
		drain();

		// directed: all sixteen charges, a point right on a charge, corners
		set_regs(0, 0, 23'd256, 5'd16);
		queue_beat(make_beat(KIND_EVAL, 0, 0, 0, 0, 0, 0));
		queue_beat(make_beat(KIND_EVAL, 0, 0, 0, 0, 12'd4095, 0));
		queue_beat(make_beat(KIND_EVAL, 0, 0, 0, 0, 0, 12'd4095));
		queue_beat(make_beat(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
		queue_beat(make_beat(KIND_EVAL, 0, 0, 0, 0, 12'd17, 12'd3));
		drain();

		// random phases across settings and idle mixes
		run_phase(0, 0, 23'd256, 5'd3, 0, 0, 70);
		run_phase(24'h800000, 24'h7fffff, 23'h7fffff, 5'd2, 63, 0, 70);
		hold_go = 1;
		run_phase(24'($urandom()), 24'($urandom()), 23'd1, 5'd1, 0, 63, 70);
		run_phase(24'($urandom()), 24'($urandom()), 23'd0, 5'd4, 30, 30, 60);
		run_phase(0, 0, 23'd4096, 5'd31, 0, 0, 10);
		run_phase(24'($urandom()), 24'($urandom()), 23'($urandom()), 5'd0, 30, 30, 60);
		run_phase(24'h7fffff, 24'h800000, 23'd300, 5'd2, 0, 0, 60);

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
